// ===== src/bitmap_block_allocator_core_defines.svh =====
// Assertion macros used by the allocator core.
`ifndef BITMAP_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BBA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// Next-cycle implication, checked outside reset.
`define BBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

// ===== src/bba_pkg.sv =====
`default_nettype none

package bba_pkg;

    // Geometry of the usage bitmap.
    localparam int MAX_BLOCKS    = 1024;
    localparam int BITS_PER_WORD = 32;
    localparam int WORD_COUNT    = (MAX_BLOCKS + BITS_PER_WORD - 1) / BITS_PER_WORD;
    localparam int WORD_IDX_W    = $clog2(WORD_COUNT);
    localparam int BIT_IDX_W     = $clog2(BITS_PER_WORD);

    // Field widths.
    localparam int TOTAL_W  = 11;
    localparam int BLOCK_W  = 10;
    localparam int STATUS_W = 2;

    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 11'd1024;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX   = TOTAL_W'(MAX_BLOCKS);
    localparam logic [TOTAL_W-1:0] WORD_BITS   = TOTAL_W'(BITS_PER_WORD);

    // Configuration register byte addresses.
    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_TOTAL_BLOCKS = 3'd0;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK            = 2'd0,
        ST_OUT_OF_BLOCKS = 2'd1,
        ST_FREE_FREE     = 2'd2,
        ST_RANGE         = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECODE = 4'b0010,
        S_EVAL   = 4'b0100,
        S_RESP   = 4'b1000
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    capture;
        logic    rd_first;
        logic    rd_next;
        logic    wr_set;
        logic    wr_clr;
        logic    res_load;
        t_status res_status;
        logic    out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic op_free;
        logic limit_zero;
        logic bn_in_range;
        logic found;
        logic bit_set;
        logic last_word;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== src/bba_if.sv =====
`default_nettype none

// Request channel: one operation per handshake.
interface bba_req_if import bba_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [0:0]         opcode;
    logic [BLOCK_W-1:0] block_number;

    modport source (output valid, output opcode, output block_number, input ready);
    modport sink   (input valid, input opcode, input block_number, output ready);
endinterface

// Response channel: one result per request.
interface bba_rsp_if import bba_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [BLOCK_W-1:0]  allocated_block;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output allocated_block, output status, input ready);
    modport sink   (input valid, input allocated_block, input status, output ready);
endinterface

`default_nettype wire

// ===== src/bba_ctrl.sv =====
`default_nettype none

module bba_ctrl import bba_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_req_valid,
    output logic         o_req_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;

    assign o_req_ready = (r_state == S_IDLE);

    // Sequencing of one request and the word scan.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res_status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.op_free) begin
                    if (!i_sts.bn_in_range) begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = ST_RANGE;
                        n_state          = S_RESP;
                    end else begin
                        o_cmd.rd_first = 1'b1;
                        n_state        = S_EVAL;
                    end
                end else if (i_sts.limit_zero) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_OUT_OF_BLOCKS;
                    n_state          = S_RESP;
                end else begin
                    o_cmd.rd_first = 1'b1;
                    n_state        = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.op_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_RESP;
                    if (i_sts.bit_set) begin
                        o_cmd.wr_clr     = 1'b1;
                        o_cmd.res_status = ST_OK;
                    end else begin
                        o_cmd.res_status = ST_FREE_FREE;
                    end
                end else if (i_sts.found) begin
                    o_cmd.wr_set     = 1'b1;
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_OK;
                    n_state          = S_RESP;
                end else if (i_sts.last_word) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = ST_OUT_OF_BLOCKS;
                    n_state          = S_RESP;
                end else begin
                    o_cmd.rd_next = 1'b1;
                end
            end
            S_RESP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== src/bba_dpath.sv =====
`default_nettype none

module bba_dpath import bba_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [0:0]         i_opcode,
    input  wire logic [BLOCK_W-1:0] i_block_number,
    input  wire logic [TOTAL_W-1:0] i_limit,
    input  wire t_dp_cmd            i_cmd,
    output t_dp_sts                 o_sts,
    bba_rsp_if.source               o_rsp
);

    // Captured request.
    logic                  r_op;
    logic [BLOCK_W-1:0]    r_bn;
    logic [WORD_IDX_W-1:0] r_word;

    // Bitmap storage with one valid bit per word; an unwritten word reads as free.
    logic [BITS_PER_WORD-1:0] r_mem [WORD_COUNT];
    logic [WORD_COUNT-1:0]    r_row_vld;
    logic [BITS_PER_WORD-1:0] r_rdata;
    logic                     r_rvld;

    // Pending result and output register.
    logic [BLOCK_W-1:0]  r_res_blk;
    t_status             r_res_st;
    logic                r_out_vld;
    logic [BLOCK_W-1:0]  r_out_blk;
    logic [STATUS_W-1:0] r_out_st;

    logic [WORD_IDX_W-1:0]    rd_addr;
    logic                     rd_en;
    logic                     wr_en;
    logic [BITS_PER_WORD-1:0] word_eff;
    logic [BITS_PER_WORD-1:0] wdata;
    logic [TOTAL_W-1:0]       word_base;
    logic [TOTAL_W-1:0]       lim_rem;
    logic [BITS_PER_WORD-1:0] range_mask;
    logic [BITS_PER_WORD-1:0] avail;
    logic [BITS_PER_WORD-1:0] lowest;
    logic [BIT_IDX_W-1:0]     found_bit;
    logic [BIT_IDX_W-1:0]     bn_bit;
    logic [WORD_IDX_W-1:0]    bn_word;

    assign bn_bit  = r_bn[BIT_IDX_W-1:0];
    assign bn_word = r_bn[BLOCK_W-1:BIT_IDX_W];

    // Request capture and word pointer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op <= i_opcode[0];
            r_bn <= i_block_number;
        end
        if (i_cmd.rd_first || i_cmd.rd_next) begin
            r_word <= rd_addr;
        end
    end

    // Read address: the freed block's word, word zero for a scan, or the next word.
    always_comb begin
        if (i_cmd.rd_next) begin
            rd_addr = r_word + 1'b1;
        end else if (r_op == OP_FREE) begin
            rd_addr = bn_word;
        end else begin
            rd_addr = '0;
        end
    end

    assign rd_en = i_cmd.rd_first || i_cmd.rd_next;
    assign wr_en = i_cmd.wr_set || i_cmd.wr_clr;

    // Bitmap memory port.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[r_word] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_rvld    <= 1'b0;
        end else begin
            if (rd_en) begin
                r_rvld <= r_row_vld[rd_addr];
            end
            if (wr_en) begin
                r_row_vld[r_word] <= 1'b1;
            end
        end
    end

    assign word_eff = r_rvld ? r_rdata : '0;

    // Blocks of the current word that lie below the limit.
    assign word_base = {1'b0, r_word, {BIT_IDX_W{1'b0}}};
    assign lim_rem   = i_limit - word_base;
    assign range_mask = (lim_rem >= WORD_BITS) ? '1
                      : ((BITS_PER_WORD'(1) << lim_rem[BIT_IDX_W-1:0]) - 1'b1);

    // Lowest free block in range: isolate the lowest set bit, then encode it.
    assign avail  = ~word_eff & range_mask;
    assign lowest = avail & (~avail + 1'b1);

    always_comb begin
        found_bit = '0;
        for (int i = 0; i < BITS_PER_WORD; i++) begin
            if (lowest[i]) begin
                found_bit = found_bit | BIT_IDX_W'(i);
            end
        end
    end

    assign wdata = i_cmd.wr_set ? (word_eff | lowest)
                                : (word_eff & ~(BITS_PER_WORD'(1) << bn_bit));

    // Status towards the controller.
    assign o_sts.op_free     = (r_op == OP_FREE);
    assign o_sts.limit_zero  = (i_limit == '0);
    assign o_sts.bn_in_range = ({1'b0, r_bn} < i_limit);
    assign o_sts.found       = |avail;
    assign o_sts.bit_set     = word_eff[bn_bit];
    assign o_sts.last_word   = ((word_base + WORD_BITS) >= i_limit);
    assign o_sts.out_free    = !r_out_vld || o_rsp.ready;

    // Pending result; the block number is only given for a successful allocate.
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_st <= i_cmd.res_status;
            if (i_cmd.wr_set) begin
                r_res_blk <= BLOCK_W'({r_word, found_bit});
            end else begin
                r_res_blk <= '0;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_blk <= r_res_blk;
            r_out_st  <= r_res_st;
        end
    end

    assign o_rsp.valid           = r_out_vld;
    assign o_rsp.allocated_block = r_out_blk;
    assign o_rsp.status          = r_out_st;

endmodule

`default_nettype wire

// ===== src/bitmap_block_allocator_core.sv =====
// Channel   Dir  Contents
// i_req     in   opcode (allocate / free), block_number
// o_rsp     out  allocated_block, status
// APB       in   total_blocks at byte address 0
//
// One request is taken at a time. A free goes from acceptance through decode and
// a read of its bitmap word to the output register (decode only if out of range);
// an allocate scans the bitmap one 32-bit word at a time through the single bitmap
// read port, up to the last word below the total. A new request can be taken
// in the cycle after the output register loads, even while that result still waits.
// Reset is synchronous; the bitmap reads as all free through per-word valid bits.
`default_nettype none
`include "bitmap_block_allocator_core_defines.svh"

module bitmap_block_allocator_core import bba_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    bba_req_if.sink                 i_req,
    bba_rsp_if.source               o_rsp,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [TOTAL_W-1:0] r_total_blocks;
    logic [TOTAL_W-1:0] limit;
    logic               cfg_wr;
    logic               rsp_fail;
    t_dp_cmd            dp_cmd;
    t_dp_sts            dp_sts;

    // Configuration register.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_TOTAL_BLOCKS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_blocks <= TOTAL_RESET;
        end else if (cfg_wr) begin
            r_total_blocks <= pwdata[TOTAL_W-1:0];
        end
    end

    assign prdata = (paddr == ADDR_TOTAL_BLOCKS) ? {{(32-TOTAL_W){1'b0}}, r_total_blocks}
                                                 : 32'd0;

    // Effective total saturates at the bitmap size.
    assign limit = (r_total_blocks > TOTAL_MAX) ? TOTAL_MAX : r_total_blocks;

    bba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    bba_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_opcode       (i_req.opcode),
        .i_block_number (i_req.block_number),
        .i_limit        (limit),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .o_rsp          (o_rsp)
    );

    // A result on offer that reports a failure.
    assign rsp_fail = o_rsp.valid && (o_rsp.status != ST_OK);

    // Only one request is in flight at a time.
    `BBA_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready)
    // The bitmap is never written while a new request may be taken.
    `BBA_ASSERT_SAME(a_no_write_idle, i_clk, i_rst_n, dp_cmd.wr_set || dp_cmd.wr_clr, !i_req.ready)
    // A block number is only reported with a successful result.
    `BBA_ASSERT_SAME(a_blk_zero_on_fail, i_clk, i_rst_n, rsp_fail, o_rsp.allocated_block == '0)

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
module tb;
    import bba_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int TAIL_CYCLES = 40;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        t_opcode            op;
        logic [BLOCK_W-1:0] blk;
    } t_request;

    typedef struct packed {
        logic [BLOCK_W-1:0] blk;
        t_status            status;
    } t_reply;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    bba_req_if req_if ();
    bba_rsp_if rsp_if ();

    bitmap_block_allocator_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow copy of the allocator: usage bitmap and the block total register.
    logic [MAX_BLOCKS-1:0] used_map;
    logic [TOTAL_W-1:0]    total_reg;

    t_request pending_requests[$];
    t_reply   awaited_results[$];
    t_request drv_next;
    t_reply   got_reply;
    t_reply   want_reply;

    int sender_idle_pct;
    int receiver_stall_pct;
    int requests_queued;
    int requests_taken;
    int replies_seen;
    int mismatches;
    int total_writes;
    int idle_cycles;
    int status_seen[4];

    // Clock generation.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Expected reply for one request, updating the shadow bitmap on the way.
    function automatic t_reply predict_reply(input t_opcode op, input logic [BLOCK_W-1:0] blk);
        t_reply r;
        int     limit;
        int     n;
        r.blk = '0;
        limit = (int'(total_reg) < MAX_BLOCKS) ? int'(total_reg) : MAX_BLOCKS;
        if (op == OP_ALLOC) begin
            r.status = ST_OUT_OF_BLOCKS;
            for (n = 0; n < limit; n++) begin
                if (!used_map[n]) begin
                    used_map[n] = 1'b1;
                    r.blk       = n[BLOCK_W-1:0];
                    r.status    = ST_OK;
                    break;
                end
            end
        end else if (int'(blk) >= limit) begin
            r.status = ST_RANGE;
        end else if (!used_map[blk]) begin
            r.status = ST_FREE_FREE;
        end else begin
            used_map[blk] = 1'b0;
            r.status      = ST_OK;
        end
        return r;
    endfunction

    // Request driver: holds the payload while stalled, predicts on acceptance.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                awaited_results.push_back(predict_reply(t_opcode'(req_if.opcode),
                                                        req_if.block_number));
                requests_taken++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    drv_next = pending_requests.pop_front();
                    req_if.valid        <= 1'b1;
                    req_if.opcode       <= drv_next.op;
                    req_if.block_number <= drv_next.blk;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Reply monitor: compares each accepted reply with the oldest expectation.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                replies_seen++;
                got_reply.blk    = rsp_if.allocated_block;
                got_reply.status = t_status'(rsp_if.status);
                status_seen[rsp_if.status]++;
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("Unexpected reply: block %0d status %0d",
                                 got_reply.blk, got_reply.status);
                end else begin
                    want_reply = awaited_results.pop_front();
                    if (got_reply.blk !== want_reply.blk
                            || got_reply.status !== want_reply.status) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("Reply %0d wrong: block %0d status %0d, expected %0d / %0d",
                                     replies_seen, got_reply.blk, got_reply.status,
                                     want_reply.blk, want_reply.status);
                    end
                end
            end
            rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Watchdog on cycles with no handshake on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("Timeout after %0d cycles without progress", idle_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    task automatic push_request(input t_opcode op, input logic [BLOCK_W-1:0] blk);
        t_request r;
        r.op  = op;
        r.blk = blk;
        pending_requests.push_back(r);
        requests_queued++;
    endtask

    // Every request yields one reply, so the block is idle once all have arrived.
    task automatic wait_drained();
        while (replies_seen != requests_queued)
            @(negedge i_clk);
    endtask

    // APB write of the block total; the register takes the value at the access edge.
    task automatic write_total(input logic [31:0] value);
        wait_drained();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TOTAL_BLOCKS;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        total_reg = value[TOTAL_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        total_writes++;
        @(negedge i_clk);
    endtask

    // One random phase. Frees mostly target blocks in use so that the bitmap
    // fills and drains; the rest land near the total or anywhere.
    task automatic run_phase(input logic [31:0] total_val, input int mode,
                             input int count, input int alloc_pct);
        int           limit;
        int           start;
        int           n;
        int           pick;
        int           roll;
        logic [BLOCK_W-1:0] blk;
        write_total(total_val);
        sender_idle_pct    = (mode == 1) ? 63 : (mode == 3) ? 18 : 0;
        receiver_stall_pct = (mode == 2) ? 63 : (mode == 3) ? 18 : 0;
        for (int k = 0; k < count; k++) begin
            while (pending_requests.size() >= 2)
                @(negedge i_clk);
            limit = (int'(total_reg) < MAX_BLOCKS) ? int'(total_reg) : MAX_BLOCKS;
            blk   = BLOCK_W'($urandom);
            if ($urandom_range(99) < alloc_pct) begin
                push_request(OP_ALLOC, blk);
            end else begin
                roll = $urandom_range(99);
                pick = -1;
                if (roll < 60 && limit > 0) begin
                    start = $urandom_range(limit - 1);
                    for (n = 0; n < limit; n++) begin
                        if (used_map[(start + n) % limit]) begin
                            pick = (start + n) % limit;
                            break;
                        end
                    end
                end else if (roll < 85) begin
                    pick = $urandom_range((limit + 8 > MAX_BLOCKS) ? MAX_BLOCKS - 1 : limit + 7);
                end
                if (pick >= 0)
                    blk = pick[BLOCK_W-1:0];
                push_request(OP_FREE, blk);
            end
        end
    endtask

    // Stimulus sequencer.
    initial begin
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        req_if.valid       = 1'b0;
        req_if.opcode      = OP_ALLOC;
        req_if.block_number = '0;
        rsp_if.ready       = 1'b0;
        used_map           = '0;
        total_reg          = TOTAL_RESET;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        requests_queued    = 0;
        requests_taken     = 0;
        replies_seen       = 0;
        mismatches         = 0;
        total_writes       = 0;
        idle_cycles        = 0;
        status_seen        = '{0, 0, 0, 0};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: first fit, double free and the all-ones block number.
        push_request(OP_ALLOC, '0);
        push_request(OP_ALLOC, '1);
        push_request(OP_FREE, '1);
        push_request(OP_FREE, '0);
        push_request(OP_FREE, '0);
        push_request(OP_ALLOC, '0);

        // Small total: run out of blocks, free beyond the total.
        write_total(32'd3);
        push_request(OP_ALLOC, '0);
        push_request(OP_ALLOC, '0);
        push_request(OP_FREE, 10'd3);
        push_request(OP_FREE, 10'd1);
        push_request(OP_ALLOC, '0);

        // Zero total, written with the unused upper bits set.
        write_total(32'hFFFF_F800);
        push_request(OP_ALLOC, '0);
        push_request(OP_FREE, '0);

        // Largest register value saturates at the bitmap size.
        write_total(32'd2047);
        push_request(OP_ALLOC, '0);
        push_request(OP_FREE, '1);

        // Shrunk total: blocks in use above it cannot be freed.
        write_total(32'd1);
        push_request(OP_FREE, 10'd2);
        push_request(OP_ALLOC, '0);
        push_request(OP_FREE, '0);
        push_request(OP_ALLOC, '0);

        write_total(32'd1024);
        push_request(OP_FREE, 10'd3);

        // Random phases over a spread of totals and idling patterns.
        run_phase(32'd8,    1, 120, 55);
        run_phase(32'd1,    2, 100, 50);
        run_phase(32'd1024, 0, 140, 70);
        run_phase(32'd33,   3, 120, 55);
        run_phase(32'd2047, 1, 120, 50);
        run_phase(32'd100,  2, 120, 60);
        run_phase(32'd5,    0, 100, 50);
        run_phase(32'd64,   3, 120, 55);
        run_phase(32'd1000, 0, 100, 45);
        run_phase(32'd512,  2,  60, 40);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests under %0d block-total settings with varied idling.",
                 requests_taken, total_writes);
        $display("Replies: %0d ok, %0d out of blocks, %0d already free, %0d out of range.",
                 status_seen[ST_OK], status_seen[ST_OUT_OF_BLOCKS],
                 status_seen[ST_FREE_FREE], status_seen[ST_RANGE]);
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches, %0d replies missing", mismatches, awaited_results.size());
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
